>>> rtl/mrc_pkg.sv
// Shared types and constants for the MIPS I integer core.
package mrc_pkg;

  localparam logic [31:0] VEC_RESET   = 32'hBFC0_0000;
  localparam logic [31:0] VEC_BOOT    = 32'hBFC0_0100;
  localparam logic [31:0] VEC_GENERAL = 32'h8000_0080;
  localparam logic [31:0] EXC_CODE_MASK = 32'h0000_007C;
  localparam logic [31:0] CAUSE_SW_MASK = 32'h0000_0300;
  localparam logic [31:0] STATUS_STACK  = 32'h0000_003F;

  localparam logic [4:0] EXC_SYS = 5'd8;
  localparam logic [4:0] EXC_BRK = 5'd9;

  localparam logic [2:0] LK_LB  = 3'd0;
  localparam logic [2:0] LK_LH  = 3'd1;
  localparam logic [2:0] LK_LW  = 3'd2;
  localparam logic [2:0] LK_LBU = 3'd3;
  localparam logic [2:0] LK_LHU = 3'd4;
  localparam logic [2:0] LK_LWL = 3'd5;
  localparam logic [2:0] LK_LWR = 3'd6;

  localparam logic [1:0] ACC_NONE  = 2'd0;
  localparam logic [1:0] ACC_READ  = 2'd1;
  localparam logic [1:0] ACC_WRITE = 2'd2;

  localparam logic [5:0] DIV_STEPS = 6'd32;

  // controller -> datapath
  typedef struct packed {
    logic read_regs;   // latch instruction, read rs
    logic read_rt;     // read rt
    logic execute;     // commit the instruction
    logic load_fin;    // commit load data
    logic md_start;    // start multiply or divide
    logic md_step;     // one divide step / multiply partial
    logic md_done;     // write HI/LO
  } mrc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic load_valid;
    logic md_last;
  } mrc_stat_t;

endpackage

>>> rtl/mrc_ctrl.sv
// Sequencing state machine for the integer core.
module mrc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  output logic                out_valid,
  input  logic                out_ready,
  input  mrc_pkg::mrc_stat_t  stat,
  output mrc_pkg::mrc_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RS   = 3'd1;
  localparam logic [2:0] S_RT   = 3'd2;
  localparam logic [2:0] S_EXE  = 3'd3;
  localparam logic [2:0] S_MD   = 3'd4;
  localparam logic [2:0] S_LFIN = 3'd5;

  logic [2:0] state, state_next;
  logic       out_valid_next;
  logic       is_load;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign is_load  = func;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd            = '0;
    if (out_valid && out_ready) out_valid_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.read_regs = 1'b1;
          state_next = is_load ? S_LFIN : S_RS;
        end
      end
      S_RS: begin
        cmd.read_rt = 1'b1;
        state_next = S_RT;
      end
      S_RT: begin
        if (stat.is_mul || stat.is_div) begin
          cmd.md_start = 1'b1;
          state_next = S_MD;
        end else begin
          state_next = S_EXE;
        end
      end
      S_MD: begin
        cmd.md_step = 1'b1;
        if (stat.md_last) state_next = S_EXE;
      end
      S_EXE: begin
        cmd.execute = 1'b1;
        cmd.md_done = stat.is_mul || stat.is_div;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      S_LFIN: begin
        cmd.load_fin = stat.load_valid;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/mrc_datapath.sv
// Register file, ALU, multiply/divide unit, COP0 and memory access formatting.
module mrc_datapath (
  input  logic               clk,
  input  logic               rst,
  input  mrc_pkg::mrc_cmd_t  cmd,
  output mrc_pkg::mrc_stat_t stat,
  input  logic               func,
  input  logic [31:0]        instr_word,
  input  logic [31:0]        load_word,
  output logic [31:0]        fetch_address,
  output logic [1:0]         access_kind,
  output logic [31:0]        access_address,
  output logic [31:0]        write_word,
  output logic [3:0]         byte_enables,
  output logic               exception_taken
);

  logic [31:0] regs [32];
  logic [31:0] valid_bits;        // entries written since reset
  logic [31:0] rd_data;
  logic [4:0]  rd_addr;
  logic [31:0] iw, lw, a, b;
  logic [31:0] hi_reg, lo_reg, status_reg, cause_reg, epc_reg;
  logic [31:0] program_counter, branch_target;
  logic        delay_pending;
  logic [10:0] load_pending;
  logic        stat_rt_cap;
  logic        lfin_out;
  logic        lfin_seen;

  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd, sh;
  logic [15:0] uim;
  logic [31:0] simm, ea, btgt, jtgt, ia;
  logic [1:0]  k;

  assign op  = iw[31:26];
  assign rs  = iw[25:21];
  assign rt  = iw[20:16];
  assign rd  = iw[15:11];
  assign sh  = iw[10:6];
  assign fn  = iw[5:0];
  assign uim = iw[15:0];
  assign simm = {{16{iw[15]}}, iw[15:0]};
  assign ia  = program_counter;
  assign ea  = a + simm;
  assign k   = ea[1:0];
  assign btgt = ia + 32'd4 + {simm[29:0], 2'b00};
  assign jtgt = {ia_p4_hi(ia), iw[25:0], 2'b00};

  function automatic logic [3:0] ia_p4_hi(input logic [31:0] x);
    logic [31:0] y;
    y = x + 32'd4;
    return y[31:28];
  endfunction

  // register read: one port, registered; a delivery reads the load destination
  always_comb begin
    rd_addr = cmd.read_regs ? (func ? load_pending[6:2] : instr_word[25:21]) :
              cmd.read_rt ? rt : load_pending[6:2];
  end

  always_ff @(posedge clk) begin
    rd_data <= valid_bits[rd_addr] ? regs[rd_addr] : 32'd0;
  end

  // multiply / divide unit
  logic        md_div, md_signed;
  logic [5:0]  md_cnt;
  logic [31:0] md_dvs, md_quo;
  logic [32:0] md_rem;
  logic [63:0] md_prod;
  logic [31:0] md_ma, md_mb;
  logic        md_na, md_nb, md_zero;
  logic [32:0] md_trial;
  logic [15:0] md_mb_lo;
  logic [47:0] md_pp;

  assign stat.is_mul = (op == 6'h00) && (fn == 6'h18 || fn == 6'h19);
  assign stat.is_div = (op == 6'h00) && (fn == 6'h1A || fn == 6'h1B);
  assign stat.load_valid = load_pending[10];
  assign stat.md_last = md_cnt == 6'd1;

  assign md_trial = {md_rem[31:0], md_quo[31]} - {1'b0, md_dvs};
  assign md_mb_lo = md_cnt[0] ? md_mb[15:0] : md_mb[31:16];
  assign md_pp    = md_ma * md_mb_lo;

  // rt operand is still in the read register when the unit starts
  always_ff @(posedge clk) begin
    if (cmd.md_start) begin
      md_div    <= stat.is_div;
      md_signed <= !fn[0];
      md_na     <= !fn[0] && a[31];
      md_nb     <= !fn[0] && rd_data[31];
      md_ma     <= (!fn[0] && a[31]) ? 32'd0 - a : a;
      md_mb     <= (!fn[0] && rd_data[31]) ? 32'd0 - rd_data : rd_data;
      md_dvs    <= (!fn[0] && rd_data[31]) ? 32'd0 - rd_data : rd_data;
      md_quo    <= (!fn[0] && a[31]) ? 32'd0 - a : a;
      md_rem    <= 33'd0;
      md_prod   <= 64'd0;
      md_zero   <= rd_data == 32'd0;
      md_cnt    <= stat.is_div ? mrc_pkg::DIV_STEPS : 6'd2;
    end else if (cmd.md_step) begin
      md_cnt <= md_cnt - 6'd1;
      if (md_div) begin
        if (!md_trial[32]) begin
          md_rem <= {1'b0, md_trial[31:0]};
          md_quo <= {md_quo[30:0], 1'b1};
        end else begin
          md_rem <= {md_rem[31:0], md_quo[31]};
          md_quo <= {md_quo[30:0], 1'b0};
        end
      end else begin
        // 32x16 partial product per cycle, high half first
        md_prod <= {md_prod[47:0], 16'd0} + {16'd0, md_pp};
      end
    end
  end

  logic [63:0] mul_res;
  logic [31:0] div_q, div_r;
  assign mul_res = (md_na != md_nb) ? 64'd0 - md_prod : md_prod;
  assign div_q = (md_na != md_nb) ? 32'd0 - md_quo : md_quo;
  assign div_r = md_na ? 32'd0 - md_rem[31:0] : md_rem[31:0];

  // execution
  logic        wr_en;
  logic [4:0]  wr_addr;
  logic [31:0] wr_val;
  logic [31:0] pc_n, bt_n, hi_n, lo_n, st_n, ca_n, epc_n;
  logic        dp_n, exc;
  logic [10:0] lp_n;
  logic [1:0]  kind;
  logic [31:0] aaddr, wword;
  logic [3:0]  be;
  logic [2:0]  lk;
  logic        is_ld;
  logic [4:0]  exc_code;
  logic        do_exc;
  logic        slt_s;

  function automatic logic lt_signed(input logic [31:0] x, input logic [31:0] y);
    return (x ^ 32'h8000_0000) < (y ^ 32'h8000_0000);
  endfunction

  always_comb begin
    wr_en = 1'b0; wr_addr = rd; wr_val = 32'd0;
    hi_n = hi_reg; lo_n = lo_reg; st_n = status_reg; ca_n = cause_reg; epc_n = epc_reg;
    kind = mrc_pkg::ACC_NONE; aaddr = 32'd0; wword = 32'd0; be = 4'd0;
    lk = mrc_pkg::LK_LB; is_ld = 1'b0; do_exc = 1'b0; exc_code = mrc_pkg::EXC_SYS;
    slt_s = 1'b0;
    if (delay_pending) begin
      pc_n = branch_target; dp_n = 1'b0;
    end else begin
      pc_n = ia + 32'd4; dp_n = 1'b0;
    end
    bt_n = branch_target;
    lp_n = 11'd0;
    exc = 1'b0;
    unique case (op)
      6'h00: begin
        unique case (fn)
          6'h00: begin wr_en = 1'b1; wr_val = b << sh; end
          6'h02: begin wr_en = 1'b1; wr_val = b >> sh; end
          6'h03: begin wr_en = 1'b1; wr_val = $signed(b) >>> sh; end
          6'h04: begin wr_en = 1'b1; wr_val = b << a[4:0]; end
          6'h06: begin wr_en = 1'b1; wr_val = b >> a[4:0]; end
          6'h07: begin wr_en = 1'b1; wr_val = $signed(b) >>> a[4:0]; end
          6'h08: begin bt_n = a; dp_n = 1'b1; end
          6'h09: begin wr_en = 1'b1; wr_val = ia + 32'd8; bt_n = a; dp_n = 1'b1; end
          6'h0C: begin do_exc = 1'b1; exc_code = mrc_pkg::EXC_SYS; end
          6'h0D: begin do_exc = 1'b1; exc_code = mrc_pkg::EXC_BRK; end
          6'h10: begin wr_en = 1'b1; wr_val = hi_reg; end
          6'h11: hi_n = a;
          6'h12: begin wr_en = 1'b1; wr_val = lo_reg; end
          6'h13: lo_n = a;
          6'h18, 6'h19: begin
            lo_n = md_signed ? mul_res[31:0] : md_prod[31:0];
            hi_n = md_signed ? mul_res[63:32] : md_prod[63:32];
          end
          6'h1A, 6'h1B: begin
            if (!md_zero) begin lo_n = div_q; hi_n = div_r; end
          end
          6'h20, 6'h21: begin wr_en = 1'b1; wr_val = a + b; end
          6'h22, 6'h23: begin wr_en = 1'b1; wr_val = a - b; end
          6'h24: begin wr_en = 1'b1; wr_val = a & b; end
          6'h25: begin wr_en = 1'b1; wr_val = a | b; end
          6'h26: begin wr_en = 1'b1; wr_val = a ^ b; end
          6'h27: begin wr_en = 1'b1; wr_val = ~(a | b); end
          6'h2A: begin wr_en = 1'b1; wr_val = {31'd0, lt_signed(a, b)}; end
          6'h2B: begin wr_en = 1'b1; wr_val = {31'd0, a < b}; end
          default: ;
        endcase
      end
      6'h01: begin
        if (rt == 5'h10 || rt == 5'h11) begin
          wr_en = 1'b1; wr_addr = 5'd31; wr_val = ia + 32'd8;
        end
        if (rt == 5'h00 || rt == 5'h10) begin
          if (a[31]) begin bt_n = btgt; dp_n = 1'b1; end
        end else if (rt == 5'h01 || rt == 5'h11) begin
          if (!a[31]) begin bt_n = btgt; dp_n = 1'b1; end
        end
      end
      6'h02: begin bt_n = jtgt; dp_n = 1'b1; end
      6'h03: begin
        wr_en = 1'b1; wr_addr = 5'd31; wr_val = ia + 32'd8; bt_n = jtgt; dp_n = 1'b1;
      end
      6'h04: if (a == b) begin bt_n = btgt; dp_n = 1'b1; end
      6'h05: if (a != b) begin bt_n = btgt; dp_n = 1'b1; end
      6'h06: if (a == 32'd0 || a[31]) begin bt_n = btgt; dp_n = 1'b1; end
      6'h07: if (a != 32'd0 && !a[31]) begin bt_n = btgt; dp_n = 1'b1; end
      6'h08, 6'h09: begin wr_en = 1'b1; wr_addr = rt; wr_val = a + simm; end
      6'h0A: begin wr_en = 1'b1; wr_addr = rt; slt_s = lt_signed(a, simm);
        wr_val = {31'd0, slt_s}; end
      6'h0B: begin wr_en = 1'b1; wr_addr = rt; wr_val = {31'd0, a < simm}; end
      6'h0C: begin wr_en = 1'b1; wr_addr = rt; wr_val = a & {16'd0, uim}; end
      6'h0D: begin wr_en = 1'b1; wr_addr = rt; wr_val = a | {16'd0, uim}; end
      6'h0E: begin wr_en = 1'b1; wr_addr = rt; wr_val = a ^ {16'd0, uim}; end
      6'h0F: begin wr_en = 1'b1; wr_addr = rt; wr_val = {uim, 16'd0}; end
      6'h10: begin
        if (rs[4]) begin
          if (fn == 6'h10) st_n = {status_reg[31:4], status_reg[5:2]};
        end else if (rs == 5'h00) begin
          wr_en = 1'b1; wr_addr = rt;
          wr_val = (rd == 5'd12) ? status_reg : (rd == 5'd13) ? cause_reg :
                   (rd == 5'd14) ? epc_reg : 32'd0;
        end else if (rs == 5'h04) begin
          if (rd == 5'd12) st_n = b;
          else if (rd == 5'd13)
            ca_n = (cause_reg & ~mrc_pkg::CAUSE_SW_MASK) | (b & mrc_pkg::CAUSE_SW_MASK);
        end
      end
      6'h20: begin is_ld = 1'b1; lk = mrc_pkg::LK_LB; end
      6'h21: begin is_ld = 1'b1; lk = mrc_pkg::LK_LH; end
      6'h22: begin is_ld = 1'b1; lk = mrc_pkg::LK_LWL; end
      6'h23: begin is_ld = 1'b1; lk = mrc_pkg::LK_LW; end
      6'h24: begin is_ld = 1'b1; lk = mrc_pkg::LK_LBU; end
      6'h25: begin is_ld = 1'b1; lk = mrc_pkg::LK_LHU; end
      6'h26: begin is_ld = 1'b1; lk = mrc_pkg::LK_LWR; end
      6'h28: begin
        kind = mrc_pkg::ACC_WRITE; aaddr = {ea[31:2], 2'b00};
        wword = {24'd0, b[7:0]} << {k, 3'b000}; be = 4'd1 << k;
      end
      6'h29: begin
        kind = mrc_pkg::ACC_WRITE; aaddr = {ea[31:2], 2'b00};
        wword = {16'd0, b[15:0]} << {k[1], 4'b0000}; be = 4'd3 << {k[1], 1'b0};
      end
      6'h2A: begin
        kind = mrc_pkg::ACC_WRITE; aaddr = {ea[31:2], 2'b00};
        wword = b >> {~k, 3'b000};
        be = unsigned'(4'((5'd1 << (3'(k) + 3'd1)) - 5'd1));
      end
      6'h2B: begin
        kind = mrc_pkg::ACC_WRITE; aaddr = {ea[31:2], 2'b00}; wword = b; be = 4'hF;
      end
      6'h2E: begin
        kind = mrc_pkg::ACC_WRITE; aaddr = {ea[31:2], 2'b00};
        wword = b << {k, 3'b000}; be = 4'hF << k;
      end
      default: ;
    endcase
    if (do_exc) begin
      exc = 1'b1;
      epc_n = delay_pending ? ia - 32'd4 : ia;
      ca_n = (cause_reg & ~(mrc_pkg::EXC_CODE_MASK | 32'h8000_0000)) |
             ({25'd0, exc_code, 2'b00} & mrc_pkg::EXC_CODE_MASK);
      if (delay_pending) ca_n[31] = 1'b1;
      st_n = (status_reg & ~mrc_pkg::STATUS_STACK) |
             ({status_reg[29:0], 2'b00} & mrc_pkg::STATUS_STACK);
      pc_n = st_n[22] ? mrc_pkg::VEC_BOOT : mrc_pkg::VEC_GENERAL;
      bt_n = pc_n + 32'd4;
      dp_n = 1'b0;
    end
    if (is_ld) begin
      kind = mrc_pkg::ACC_READ;
      aaddr = {ea[31:2], 2'b00};
      lp_n = {1'b1, lk, rt, k};
    end
  end

  // load completion
  logic [1:0]  lk_off;
  logic [7:0]  lbyte;
  logic [15:0] lhalf;
  logic [31:0] ld_val;
  logic [31:0] old;
  assign lk_off = load_pending[1:0];
  assign lbyte = 8'(lw >> {lk_off, 3'b000});
  assign lhalf = 16'(lw >> {lk_off[1], 4'b0000});
  assign old   = rd_data;

  always_comb begin
    unique case (load_pending[9:7])
      mrc_pkg::LK_LB:  ld_val = {{24{lbyte[7]}}, lbyte};
      mrc_pkg::LK_LH:  ld_val = {{16{lhalf[15]}}, lhalf};
      mrc_pkg::LK_LW:  ld_val = lw;
      mrc_pkg::LK_LBU: ld_val = {24'd0, lbyte};
      mrc_pkg::LK_LHU: ld_val = {16'd0, lhalf};
      mrc_pkg::LK_LWL: ld_val = (old & (32'h00FF_FFFF >> {lk_off, 3'b000})) |
                                (lw << {~lk_off, 3'b000});
      mrc_pkg::LK_LWR: ld_val = (old & (32'hFFFF_FF00 << {~lk_off, 3'b000})) |
                                (lw >> {lk_off, 3'b000});
      default:         ld_val = old;
    endcase
  end

  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;
  always_comb begin
    rf_we = 1'b0; rf_wa = wr_addr; rf_wd = wr_val;
    if (cmd.execute) rf_we = wr_en;
    else if (cmd.load_fin) begin
      rf_we = 1'b1; rf_wa = load_pending[6:2]; rf_wd = ld_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we && rf_wa != 5'd0) regs[rf_wa] <= rf_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.read_regs) begin
      iw <= instr_word;
      lw <= load_word;
    end
    // operand capture follows the registered read, in the cycle after it
    if (cmd.read_rt) a <= rd_data;
    if (stat_rt_cap) b <= rd_data;
  end

  always_ff @(posedge clk) begin
    if (rst) stat_rt_cap <= 1'b0;
    else stat_rt_cap <= cmd.read_rt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= 32'd0;
      hi_reg <= 32'd0; lo_reg <= 32'd0; status_reg <= 32'd0;
      cause_reg <= 32'd0; epc_reg <= 32'd0;
      program_counter <= mrc_pkg::VEC_RESET;
      branch_target <= mrc_pkg::VEC_RESET + 32'd4;
      delay_pending <= 1'b0;
      load_pending <= 11'd0;
      fetch_address <= mrc_pkg::VEC_RESET;
      access_kind <= mrc_pkg::ACC_NONE;
      access_address <= 32'd0; write_word <= 32'd0; byte_enables <= 4'd0;
      exception_taken <= 1'b0;
    end else begin
      if (rf_we && rf_wa != 5'd0) valid_bits[rf_wa] <= 1'b1;
      if (cmd.execute) begin
        if (cmd.md_done || !(stat.is_mul || stat.is_div)) begin
          hi_reg <= hi_n; lo_reg <= lo_n;
        end
        status_reg <= st_n; cause_reg <= ca_n; epc_reg <= epc_n;
        program_counter <= pc_n; branch_target <= bt_n; delay_pending <= dp_n;
        load_pending <= lp_n;
        fetch_address <= pc_n;
        access_kind <= kind; access_address <= aaddr;
        write_word <= (kind == mrc_pkg::ACC_WRITE) ? wword : 32'd0;
        byte_enables <= (kind == mrc_pkg::ACC_WRITE) ? be : 4'd0;
        exception_taken <= exc;
      end else if (cmd.load_fin) begin
        load_pending <= 11'd0;
      end
      if (lfin_out) begin
        fetch_address <= program_counter;
        access_kind <= mrc_pkg::ACC_NONE; access_address <= 32'd0;
        write_word <= 32'd0; byte_enables <= 4'd0; exception_taken <= 1'b0;
      end
    end
  end

  // a delivery step reports the unchanged fetch address and no access
  always_ff @(posedge clk) begin
    if (rst) lfin_seen <= 1'b0;
    else lfin_seen <= cmd.read_regs;
  end
  assign lfin_out = lfin_seen && !cmd.read_rt;

endmodule

>>> rtl/mips_r3000_integer_core_top.sv
// MIPS I integer core: one instruction or one load delivery per transaction.
// An ordinary instruction passes through acceptance, the rs read, the rt
// read and the commit, using the single register file read port; a load
// delivery is accepted and then committed. MULT/MULTU add two 32x16
// partial products, DIV/DIVU add a pass through the restoring divider. The
// next transaction is accepted once the result has been taken. Reset is
// synchronous; the register file reads zero until each entry is written.
module mips_r3000_integer_core_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] instr_word,
  input  logic [31:0] load_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] fetch_address,
  output logic [1:0]  access_kind,
  output logic [31:0] access_address,
  output logic [31:0] write_word,
  output logic [3:0]  byte_enables,
  output logic        exception_taken
);

  mrc_pkg::mrc_cmd_t  cmd;
  mrc_pkg::mrc_stat_t stat;

  mrc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .func(func),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  mrc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .func(func), .instr_word(instr_word),
    .load_word(load_word), .fetch_address(fetch_address), .access_kind(access_kind),
    .access_address(access_address), .write_word(write_word),
    .byte_enables(byte_enables), .exception_taken(exception_taken)
  );

endmodule

>>> rtl/mrc_checker.sv
// Port-level checks for the integer core, bound to the top level.
module mrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  access_kind,
  input logic [31:0] access_address,
  input logic [3:0]  byte_enables
);

  a_no_accept_while_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_result_follows_accept: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_ready) else $error("result without busy phase");

  a_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> access_address[1:0] == 2'b00) else $error("unaligned access");

  a_be_write_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && access_kind != mrc_pkg::ACC_WRITE |-> byte_enables == 4'd0)
    else $error("byte enables without write");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

endmodule

bind mips_r3000_integer_core_top mrc_checker u_mrc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .access_kind(access_kind),
  .access_address(access_address), .byte_enables(byte_enables)
);

>>> verif/mips_r3000_integer_core_top_tb.sv
// Self-checking testbench for the MIPS I integer core: program-shaped stimulus, in-bench predictor.
`timescale 1ns / 100ps

module mips_r3000_integer_core_top_tb;

  typedef struct packed {
    logic        func;
    logic [31:0] instr_word;
    logic [31:0] load_word;
  } core_in_t;

  typedef struct packed {
    logic [31:0] fetch_address;
    logic [1:0]  access_kind;
    logic [31:0] access_address;
    logic [31:0] write_word;
    logic [3:0]  byte_enables;
    logic        exception_taken;
  } core_out_t;

  localparam logic [5:0] OP_SPECIAL = 6'h00, OP_REGIMM = 6'h01, OP_J = 6'h02, OP_JAL = 6'h03,
    OP_BEQ = 6'h04, OP_BNE = 6'h05, OP_BLEZ = 6'h06, OP_BGTZ = 6'h07, OP_ADDI = 6'h08,
    OP_ADDIU = 6'h09, OP_SLTI = 6'h0A, OP_SLTIU = 6'h0B, OP_ANDI = 6'h0C, OP_ORI = 6'h0D,
    OP_XORI = 6'h0E, OP_LUI = 6'h0F, OP_COP0 = 6'h10, OP_LB = 6'h20, OP_LH = 6'h21,
    OP_LWL = 6'h22, OP_LW = 6'h23, OP_LBU = 6'h24, OP_LHU = 6'h25, OP_LWR = 6'h26,
    OP_SB = 6'h28, OP_SH = 6'h29, OP_SWL = 6'h2A, OP_SW = 6'h2B, OP_SWR = 6'h2E,
    OP_LWC2 = 6'h32, OP_SWC2 = 6'h3A;
  localparam logic [5:0] FN_SLL = 6'h00, FN_SRL = 6'h02, FN_SRA = 6'h03, FN_SLLV = 6'h04,
    FN_SRLV = 6'h06, FN_SRAV = 6'h07, FN_JR = 6'h08, FN_JALR = 6'h09, FN_SYSCALL = 6'h0C,
    FN_BREAK = 6'h0D, FN_MFHI = 6'h10, FN_MTHI = 6'h11, FN_MFLO = 6'h12, FN_MTLO = 6'h13,
    FN_MULT = 6'h18, FN_MULTU = 6'h19, FN_DIV = 6'h1A, FN_DIVU = 6'h1B, FN_ADD = 6'h20,
    FN_ADDU = 6'h21, FN_SUB = 6'h22, FN_SUBU = 6'h23, FN_AND = 6'h24, FN_OR = 6'h25,
    FN_XOR = 6'h26, FN_NOR = 6'h27, FN_SLT = 6'h2A, FN_SLTU = 6'h2B, FN_RFE = 6'h10;
  localparam logic [4:0] RI_BLTZ = 5'h00, RI_BGEZ = 5'h01, RI_BLTZAL = 5'h10,
    RI_BGEZAL = 5'h11;
  localparam logic [4:0] C0_MF = 5'h00, C0_MT = 5'h04, C0_CO = 5'h10;
  localparam logic [4:0] C0_STATUS = 5'd12, C0_CAUSE = 5'd13, C0_EPC = 5'd14;
  localparam logic       FUNC_EXEC = 1'b0, FUNC_LOAD = 1'b1;

  logic        clk, rst;
  logic        in_valid, in_ready, func;
  logic [31:0] instr_word, load_word;
  logic        out_valid, out_ready;
  logic [31:0] fetch_address, access_address, write_word;
  logic [1:0]  access_kind;
  logic [3:0]  byte_enables;
  logic        exception_taken;

  mips_r3000_integer_core_top dut (.*);

  // predictor state
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q, sr_q, cause_q, epc_q, pc_q, btgt_q;
  logic        slot_q;
  logic        ld_valid;
  logic [2:0]  ld_kind;
  logic [4:0]  ld_rt;
  logic [1:0]  ld_off;

  core_in_t  pending_items[$];
  core_out_t expected_results[$];
  int        errors;
  bit        drain_now;
  bit        quiet_tail;
  int        in_idle, out_idle;

  function automatic logic [31:0] sext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic void wr_gpr(logic [4:0] r, logic [31:0] v);
    if (r != 0) gpr[r] = v;
  endfunction

  function automatic void do_branch(logic [31:0] t);
    btgt_q = t;
    slot_q = 1'b1;
  endfunction

  function automatic void do_exception(logic [4:0] code, logic [31:0] ia, logic in_slot);
    epc_q   = in_slot ? ia - 32'd4 : ia;
    cause_q = (cause_q & ~(mrc_pkg::EXC_CODE_MASK | 32'h8000_0000)) | ({27'd0, code} << 2);
    if (in_slot) cause_q[31] = 1'b1;
    sr_q    = (sr_q & ~mrc_pkg::STATUS_STACK) | ((sr_q << 2) & mrc_pkg::STATUS_STACK);
    pc_q    = sr_q[22] ? mrc_pkg::VEC_BOOT : mrc_pkg::VEC_GENERAL;
    btgt_q  = pc_q + 32'd4;
    slot_q  = 1'b0;
  endfunction

  function automatic void complete_load(logic [31:0] m);
    logic [31:0] old, bt, hw;
    old = gpr[ld_rt];
    bt  = (m >> (8 * ld_off)) & 32'hFF;
    hw  = (m >> (8 * {ld_off[1], 1'b0})) & 32'hFFFF;
    case (ld_kind)
      mrc_pkg::LK_LB:  wr_gpr(ld_rt, {{24{bt[7]}}, bt[7:0]});
      mrc_pkg::LK_LH:  wr_gpr(ld_rt, sext16(hw[15:0]));
      mrc_pkg::LK_LW:  wr_gpr(ld_rt, m);
      mrc_pkg::LK_LBU: wr_gpr(ld_rt, bt);
      mrc_pkg::LK_LHU: wr_gpr(ld_rt, hw);
      mrc_pkg::LK_LWL: wr_gpr(ld_rt, (old & (32'h00FF_FFFF >> (8 * ld_off))) |
                                     (m << (24 - 8 * ld_off)));
      mrc_pkg::LK_LWR: wr_gpr(ld_rt, (old & (32'hFFFF_FF00 << (24 - 8 * ld_off))) |
                                     (m >> (8 * ld_off)));
      default: ;
    endcase
    ld_valid = 1'b0;
  endfunction

  function automatic core_out_t execute_item(core_in_t it);
    core_out_t   r;
    logic [31:0] iw, a, b, simm, uim, ia, ea, brt, jt, q, rm, ma, mb;
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [63:0] prod;
    logic        in_slot, is_load, na, nb;
    logic [2:0]  lk;
    r = '0;
    is_load = 1'b0;
    lk = mrc_pkg::LK_LB;
    if (it.func == FUNC_LOAD) begin
      if (ld_valid) complete_load(it.load_word);
    end else begin
      iw = it.instr_word;
      op = iw[31:26]; rs = iw[25:21]; rt = iw[20:16]; rd = iw[15:11]; sh = iw[10:6];
      fn = iw[5:0];
      uim = {16'd0, iw[15:0]};
      simm = sext16(iw[15:0]);
      a = gpr[rs]; b = gpr[rt];
      ia = pc_q;
      ea = a + simm;
      brt = ia + 32'd4 + (simm << 2);
      jt = ((ia + 32'd4) & 32'hF000_0000) | {4'd0, iw[25:0], 2'b00};
      in_slot = slot_q;
      ld_valid = 1'b0;
      if (slot_q) begin
        pc_q = btgt_q;
        slot_q = 1'b0;
      end else pc_q = ia + 32'd4;
      case (op)
        OP_SPECIAL: case (fn)
          FN_SLL:  wr_gpr(rd, b << sh);
          FN_SRL:  wr_gpr(rd, b >> sh);
          FN_SRA:  wr_gpr(rd, $signed(b) >>> sh);
          FN_SLLV: wr_gpr(rd, b << a[4:0]);
          FN_SRLV: wr_gpr(rd, b >> a[4:0]);
          FN_SRAV: wr_gpr(rd, $signed(b) >>> a[4:0]);
          FN_JR:   do_branch(a);
          FN_JALR: begin wr_gpr(rd, ia + 32'd8); do_branch(a); end
          FN_SYSCALL: begin
            do_exception(mrc_pkg::EXC_SYS, ia, in_slot); r.exception_taken = 1'b1;
          end
          FN_BREAK: begin
            do_exception(mrc_pkg::EXC_BRK, ia, in_slot); r.exception_taken = 1'b1;
          end
          FN_MFHI: wr_gpr(rd, hi_q);
          FN_MTHI: hi_q = a;
          FN_MFLO: wr_gpr(rd, lo_q);
          FN_MTLO: lo_q = a;
          FN_MULT: begin
            prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            lo_q = prod[31:0]; hi_q = prod[63:32];
          end
          FN_MULTU: begin
            prod = {32'd0, a} * {32'd0, b};
            lo_q = prod[31:0]; hi_q = prod[63:32];
          end
          FN_DIV: if (b != 0) begin
            na = a[31]; nb = b[31];
            ma = na ? -a : a; mb = nb ? -b : b;
            q = ma / mb; rm = ma % mb;
            lo_q = (na != nb) ? -q : q;
            hi_q = na ? -rm : rm;
          end
          FN_DIVU: if (b != 0) begin lo_q = a / b; hi_q = a % b; end
          FN_ADD, FN_ADDU: wr_gpr(rd, a + b);
          FN_SUB, FN_SUBU: wr_gpr(rd, a - b);
          FN_AND:  wr_gpr(rd, a & b);
          FN_OR:   wr_gpr(rd, a | b);
          FN_XOR:  wr_gpr(rd, a ^ b);
          FN_NOR:  wr_gpr(rd, ~(a | b));
          FN_SLT:  wr_gpr(rd, {31'd0, $signed(a) < $signed(b)});
          FN_SLTU: wr_gpr(rd, {31'd0, a < b});
          default: ;
        endcase
        OP_REGIMM: case (rt)
          RI_BLTZ:   if (a[31]) do_branch(brt);
          RI_BGEZ:   if (!a[31]) do_branch(brt);
          RI_BLTZAL: begin wr_gpr(5'd31, ia + 32'd8); if (a[31]) do_branch(brt); end
          RI_BGEZAL: begin wr_gpr(5'd31, ia + 32'd8); if (!a[31]) do_branch(brt); end
          default: ;
        endcase
        OP_J:    do_branch(jt);
        OP_JAL:  begin wr_gpr(5'd31, ia + 32'd8); do_branch(jt); end
        OP_BEQ:  if (a == b) do_branch(brt);
        OP_BNE:  if (a != b) do_branch(brt);
        OP_BLEZ: if (a == 0 || a[31]) do_branch(brt);
        OP_BGTZ: if (a != 0 && !a[31]) do_branch(brt);
        OP_ADDI, OP_ADDIU: wr_gpr(rt, a + simm);
        OP_SLTI:  wr_gpr(rt, {31'd0, $signed(a) < $signed(simm)});
        OP_SLTIU: wr_gpr(rt, {31'd0, a < simm});
        OP_ANDI:  wr_gpr(rt, a & uim);
        OP_ORI:   wr_gpr(rt, a | uim);
        OP_XORI:  wr_gpr(rt, a ^ uim);
        OP_LUI:   wr_gpr(rt, uim << 16);
        OP_COP0: begin
          if (rs[4]) begin
            if (fn == FN_RFE) sr_q = (sr_q & ~32'hF) | ((sr_q >> 2) & 32'hF);
          end else if (rs == C0_MF) begin
            wr_gpr(rt, rd == C0_STATUS ? sr_q : rd == C0_CAUSE ? cause_q :
                       rd == C0_EPC ? epc_q : 32'd0);
          end else if (rs == C0_MT) begin
            if (rd == C0_STATUS) sr_q = b;
            else if (rd == C0_CAUSE)
              cause_q = (cause_q & ~mrc_pkg::CAUSE_SW_MASK) | (b & mrc_pkg::CAUSE_SW_MASK);
          end
        end
        OP_LB:  begin is_load = 1'b1; lk = mrc_pkg::LK_LB; end
        OP_LH:  begin is_load = 1'b1; lk = mrc_pkg::LK_LH; end
        OP_LWL: begin is_load = 1'b1; lk = mrc_pkg::LK_LWL; end
        OP_LW:  begin is_load = 1'b1; lk = mrc_pkg::LK_LW; end
        OP_LBU: begin is_load = 1'b1; lk = mrc_pkg::LK_LBU; end
        OP_LHU: begin is_load = 1'b1; lk = mrc_pkg::LK_LHU; end
        OP_LWR: begin is_load = 1'b1; lk = mrc_pkg::LK_LWR; end
        OP_SB: begin
          r.access_kind = mrc_pkg::ACC_WRITE; r.write_word = (b & 32'hFF) << (8 * ea[1:0]);
          r.byte_enables = 4'b0001 << ea[1:0];
        end
        OP_SH: begin
          r.access_kind = mrc_pkg::ACC_WRITE; r.write_word = (b & 32'hFFFF) << (16 * ea[1]);
          r.byte_enables = 4'b0011 << {ea[1], 1'b0};
        end
        OP_SWL: begin
          r.access_kind = mrc_pkg::ACC_WRITE; r.write_word = b >> (24 - 8 * ea[1:0]);
          r.byte_enables = 4'((5'd1 << (ea[1:0] + 1)) - 5'd1);
        end
        OP_SW: begin
          r.access_kind = mrc_pkg::ACC_WRITE; r.write_word = b; r.byte_enables = 4'hF;
        end
        OP_SWR: begin
          r.access_kind = mrc_pkg::ACC_WRITE; r.write_word = b << (8 * ea[1:0]);
          r.byte_enables = 4'hF << ea[1:0];
        end
        default: ;
      endcase
      if (r.access_kind == mrc_pkg::ACC_WRITE) r.access_address = {ea[31:2], 2'b00};
      if (is_load) begin
        r.access_kind = mrc_pkg::ACC_READ;
        r.access_address = {ea[31:2], 2'b00};
        ld_valid = 1'b1; ld_kind = lk; ld_rt = rt; ld_off = ea[1:0];
      end
    end
    r.fetch_address = pc_q;
    return r;
  endfunction

  // instruction builders
  function automatic core_in_t rtype(logic [4:0] rs, rt, rd, sh, logic [5:0] fn);
    return '{FUNC_EXEC, {OP_SPECIAL, rs, rt, rd, sh, fn}, $urandom};
  endfunction
  function automatic core_in_t itype(logic [5:0] op, logic [4:0] rs, rt, logic [15:0] im);
    return '{FUNC_EXEC, {op, rs, rt, im}, $urandom};
  endfunction
  function automatic core_in_t deliver(logic [31:0] w);
    return '{FUNC_LOAD, $urandom, w};
  endfunction

  function automatic logic [5:0] pick_op();
    logic [5:0] ops[] = '{OP_SPECIAL, OP_SPECIAL, OP_SPECIAL, OP_REGIMM, OP_J, OP_JAL, OP_BEQ,
      OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
      OP_XORI, OP_LUI, OP_LUI, OP_ORI, OP_COP0, OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU,
      OP_LWR, OP_SB, OP_SH, OP_SWL, OP_SW, OP_SWR, OP_LWC2, OP_SWC2};
    return ops[$urandom_range(ops.size() - 1)];
  endfunction

  function automatic logic [5:0] pick_fn();
    logic [5:0] fns[] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_JALR,
      FN_SYSCALL, FN_BREAK, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV,
      FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT,
      FN_SLTU, 6'h3F};
    return fns[$urandom_range(fns.size() - 1)];
  endfunction

  // random instruction, biased to sensible fields; loads usually followed by delivery
  task automatic add_random();
    core_in_t it;
    logic [5:0] op;
    logic [4:0] sel;
    it = '{FUNC_EXEC, $urandom, $urandom};
    op = pick_op();
    it.instr_word[31:26] = op;
    if (op == OP_SPECIAL) it.instr_word[5:0] = pick_fn();
    if (op == OP_COP0) begin
      sel = 5'($urandom_range(3));
      it.instr_word[25:21] = sel == 0 ? C0_MF : sel == 1 ? C0_MT : sel == 2 ? C0_CO : 5'h02;
      it.instr_word[15:11] = 5'($urandom_range(11, 15));
      if (sel == 2 && $urandom_range(3) != 0) it.instr_word[5:0] = FN_RFE;
      // often write zero from r0
      if (sel == 1 && $urandom_range(1)) it.instr_word[20:16] = 5'd0;
    end
    if (op == OP_REGIMM)
      it.instr_word[20:16] = $urandom_range(1) ? RI_BLTZAL : 5'($urandom_range(1));
    pending_items.push_back(it);
    if (op inside {OP_LB, OP_LH, OP_LWL, OP_LW, OP_LBU, OP_LHU, OP_LWR} &&
        $urandom_range(9) != 0)
      pending_items.push_back(deliver($urandom));
    else if ($urandom_range(30) == 0)
      pending_items.push_back(deliver($urandom));  // stray delivery
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("mips_r3000_integer_core_top_tb: done, errors");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_idle <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_idle > 0) begin
        in_valid <= 1'b0;
        in_idle <= in_idle - 1;
      end else if (pending_items.size() > 0 &&
                   !(drain_now && expected_results.size() > 0)) begin
        in_valid <= 1'b1;
        {func, instr_word, load_word} <= pending_items[0];
        expected_results.push_back(execute_item(pending_items.pop_front()));
        if (!quiet_tail && $urandom_range(7) == 0) in_idle <= $urandom_range(1, 5);
      end else in_valid <= 1'b0;
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    core_out_t got, exp;
    if (rst) begin
      out_ready <= 1'b0;
      out_idle <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{fetch_address, access_kind, access_address, write_word, byte_enables,
                exception_taken};
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %h", $time, got);
        end else begin
          exp = expected_results.pop_front();
          if (got.fetch_address !== exp.fetch_address) begin
            errors++;
            $display("%0t: fetch_address exp %h got %h", $time, exp.fetch_address,
                     got.fetch_address);
          end
          if (got.access_kind !== exp.access_kind) begin
            errors++;
            $display("%0t: access_kind exp %0d got %0d", $time, exp.access_kind,
                     got.access_kind);
          end
          if (got.access_address !== exp.access_address) begin
            errors++;
            $display("%0t: access_address exp %h got %h", $time, exp.access_address,
                     got.access_address);
          end
          if (got.write_word !== exp.write_word) begin
            errors++;
            $display("%0t: write_word exp %h got %h", $time, exp.write_word, got.write_word);
          end
          if (got.byte_enables !== exp.byte_enables) begin
            errors++;
            $display("%0t: byte_enables exp %h got %h", $time, exp.byte_enables,
                     got.byte_enables);
          end
          if (got.exception_taken !== exp.exception_taken) begin
            errors++;
            $display("%0t: exception_taken exp %b got %b", $time, exp.exception_taken,
                     got.exception_taken);
          end
        end
      end
      if (out_idle > 0) begin
        out_ready <= 1'b0;
        out_idle <= out_idle - 1;
      end else if (!quiet_tail && $urandom_range(7) == 0) begin
        out_ready <= 1'b0;
        out_idle <= $urandom_range(0, 4);
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    int n;
    errors = 0;
    drain_now = 1'b0;
    quiet_tail = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    out_ready = 1'b0;
    func = FUNC_EXEC;
    instr_word = '0;
    load_word = '0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    hi_q = '0; lo_q = '0; sr_q = '0; cause_q = '0; epc_q = '0;
    pc_q = mrc_pkg::VEC_RESET; btgt_q = mrc_pkg::VEC_RESET + 32'd4; slot_q = 1'b0;
    ld_valid = 1'b0;
    ld_kind = mrc_pkg::LK_LB; ld_rt = '0; ld_off = '0;

    // directed: operand extremes, multiply/divide corners, loads, stores, exceptions
    pending_items.push_back(itype(OP_LUI, 5'd0, 5'd1, 16'h8000));        // r1 = 0x80000000
    pending_items.push_back(itype(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));      // r2 = -1
    pending_items.push_back(itype(OP_ORI, 5'd2, 5'd3, 16'hFFFF));
    pending_items.push_back(rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV));       // overflow divide
    pending_items.push_back(rtype(5'd0, 5'd0, 5'd4, 5'd0, FN_MFLO));
    pending_items.push_back(rtype(5'd0, 5'd0, 5'd5, 5'd0, FN_MFHI));
    pending_items.push_back(rtype(5'd1, 5'd0, 5'd0, 5'd0, FN_DIVU));      // divide by zero
    pending_items.push_back(rtype(5'd2, 5'd2, 5'd0, 5'd0, FN_MULT));
    pending_items.push_back(rtype(5'd2, 5'd2, 5'd0, 5'd0, FN_MULTU));
    pending_items.push_back(rtype(5'd0, 5'd2, 5'd6, 5'd31, FN_SRA));
    pending_items.push_back(itype(OP_LWL, 5'd1, 5'd7, 16'h0003));
    pending_items.push_back(deliver(32'hFFFF_FFFF));
    pending_items.push_back(itype(OP_LWR, 5'd1, 5'd0, 16'h0001));         // load to r0
    pending_items.push_back(deliver(32'h1234_5678));
    pending_items.push_back(deliver(32'h0));                              // nothing pending
    pending_items.push_back(itype(OP_LH, 5'd1, 5'd8, 16'h0003));          // misaligned
    pending_items.push_back(itype(OP_SWL, 5'd1, 5'd2, 16'h0001));         // abandons load
    pending_items.push_back(itype(OP_SWR, 5'd1, 5'd2, 16'h0002));
    pending_items.push_back(itype(OP_SH, 5'd1, 5'd2, 16'h0003));
    pending_items.push_back(itype(OP_BEQ, 5'd0, 5'd0, 16'h0010));
    pending_items.push_back(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));   // in delay slot
    pending_items.push_back(itype(OP_COP0, C0_MF, 5'd9, {C0_CAUSE, 11'd0}));
    pending_items.push_back(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_BREAK));
    pending_items.push_back(itype(OP_COP0, C0_CO, 5'd0, {5'd0, 5'd0, FN_RFE}));
    pending_items.push_back('{FUNC_EXEC, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (pending_items.size() == 0);
    // hold the sender before each item until every expected result has drained
    drain_now = 1'b1;
    for (n = 0; n < 200; n++) add_random();
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    drain_now = 1'b0;
    for (n = 0; n < 120; n++) add_random();
    wait (pending_items.size() == 0);
    quiet_tail = 1'b1;
    for (n = 0; n < 80; n++) add_random();
    wait (pending_items.size() == 0 && expected_results.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("mips_r3000_integer_core_top_tb: done, clean");
    else $display("mips_r3000_integer_core_top_tb: done, errors");
    $finish;
  end
endmodule

>>> filelist.f
rtl/mrc_pkg.sv
rtl/mrc_ctrl.sv
rtl/mrc_datapath.sv
rtl/mips_r3000_integer_core_top.sv
rtl/mrc_checker.sv
verif/mips_r3000_integer_core_top_tb.sv
